// ===== rtl/dpsr_pkg.sv =====
// Package for the DMA pointer shadow registers block.
// Holds the hit codes, register indexes, address constants and the match struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dpsr_pkg;

  localparam int unsigned NumShadows = 4;
  localparam int unsigned OffsetWidth = 32;
  localparam int unsigned DataWidth = 64;
  localparam int unsigned CapWidth = 8;
  localparam int unsigned CfgIndexWidth = 8;
  localparam int unsigned CfgDataWidth = 32;

  // Largest legal size code (8 bytes).
  localparam logic [2:0] SizeCodeMax = 3'd3;

  // Register offsets from their base registers.
  localparam logic [OffsetWidth-1:0] CmdRingOffset  = 32'h18;
  localparam logic [OffsetWidth-1:0] CtxArrayOffset = 32'h30;
  localparam logic [OffsetWidth-1:0] EvtTableOffset = 32'h30;
  localparam logic [OffsetWidth-1:0] DeqPtrOffset   = 32'h38;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] CfgCapLength     = 8'd0;
  localparam logic [CfgIndexWidth-1:0] CfgRuntimeOffset = 8'd1;

  typedef enum logic [2:0] {
    HIT_NONE      = 3'd0,
    HIT_CMD_RING  = 3'd1,
    HIT_CTX_ARRAY = 3'd2,
    HIT_EVT_TABLE = 3'd3,
    HIT_DEQ_PTR   = 3'd4
  } hit_e;

  // Containment result of one shadow register against one access.
  typedef struct packed {
    logic       hit;
    logic [2:0] lane;
  } slot_match_t;

endpackage

`default_nettype wire

// ===== rtl/dpsr_slot_match.sv =====
// Containment test of one access against one 8-byte shadow register.
// Depends on dpsr_pkg for widths and the match struct.
`timescale 1ns / 1ps
`default_nettype none

module dpsr_slot_match (
  input  wire logic [dpsr_pkg::OffsetWidth-1:0] base_i,
  input  wire logic [dpsr_pkg::OffsetWidth-1:0] access_offset_i,
  input  wire logic [1:0]                       size_i,
  output dpsr_pkg::slot_match_t                 match_o
);

  logic [dpsr_pkg::OffsetWidth:0] access_end;
  logic [dpsr_pkg::OffsetWidth:0] slot_end;
  logic [3:0]                     num_bytes;

  always_comb begin
    num_bytes = 4'd1 << size_i;
    // Both ends are taken unwrapped, one bit wider than the offsets.
    access_end = {1'b0, access_offset_i} + {{(dpsr_pkg::OffsetWidth-3){1'b0}}, num_bytes};
    slot_end   = {1'b0, base_i} + {{(dpsr_pkg::OffsetWidth-3){1'b0}}, 4'd8};
    match_o.hit  = (access_offset_i >= base_i) && (access_end <= slot_end);
    match_o.lane = access_offset_i[2:0] - base_i[2:0];
  end

endmodule

`default_nettype wire

// ===== rtl/dma_pointer_shadow_registers_core.sv =====
// Snoops controller register writes and keeps shadow copies of four DMA pointers.
// An accepted write waits in the input register and loads the result register once that one is free or being taken.
// Throughput: one transaction per cycle while out_stall_i is low; the shadow read-modify-write
// sits between the input register and the result register, so back-to-back hits need no forwarding.
// Reset: shadows, cap_length and runtime_offset clear to zero; both stages empty.
// Depends on dpsr_pkg and dpsr_slot_match.
`timescale 1ns / 1ps
`default_nettype none

module dma_pointer_shadow_registers_core (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic [dpsr_pkg::OffsetWidth-1:0]       access_offset_i,
  input  wire logic [dpsr_pkg::DataWidth-1:0]         write_data_i,
  input  wire logic [2:0]                             size_code_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic [2:0]                                  hit_register_o,
  output logic [dpsr_pkg::DataWidth-1:0]              shadow_value_o,
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [dpsr_pkg::CfgIndexWidth-1:0]     cfg_index_i,
  input  wire logic [dpsr_pkg::CfgDataWidth-1:0]      cfg_data_i
);

  // Configuration registers.
  logic [dpsr_pkg::CapWidth-1:0]    cap_length_q;
  logic [dpsr_pkg::OffsetWidth-1:0] runtime_offset_q;

  // Input stage.
  logic                             s1_valid_q;
  logic [dpsr_pkg::OffsetWidth-1:0] s1_offset_q;
  logic [dpsr_pkg::DataWidth-1:0]   s1_data_q;
  logic [2:0]                       s1_size_q;

  // Result stage.
  logic                             out_valid_q;
  dpsr_pkg::hit_e                   hit_q, hit_d;
  logic [dpsr_pkg::DataWidth-1:0]   value_q, value_d;

  logic [dpsr_pkg::DataWidth-1:0]   shadow_q [dpsr_pkg::NumShadows];

  logic                             advance;
  logic                             size_ok;
  logic [dpsr_pkg::OffsetWidth-1:0] slot_base [dpsr_pkg::NumShadows];
  dpsr_pkg::slot_match_t            slot_match [dpsr_pkg::NumShadows];
  logic                             any_hit;
  logic [1:0]                       sel_idx;
  logic [2:0]                       sel_lane;
  logic [7:0]                       size_lanes;
  logic [7:0]                       lane_en;
  logic [dpsr_pkg::DataWidth-1:0]   lane_mask;
  logic [dpsr_pkg::DataWidth-1:0]   data_shifted;
  logic [dpsr_pkg::DataWidth-1:0]   merged;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_length_q     <= '0;
      runtime_offset_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        dpsr_pkg::CfgCapLength:     cap_length_q <= cfg_data_i[dpsr_pkg::CapWidth-1:0];
        dpsr_pkg::CfgRuntimeOffset: runtime_offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The input stage moves on whenever the result register is free or being taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;

  // An empty input stage takes a transaction even while the result waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_offset_q <= access_offset_i;
      s1_data_q   <= write_data_i;
      s1_size_q   <= size_code_i;
    end
  end

  // Register bases wrap modulo 2^32.
  assign slot_base[0] = {{(dpsr_pkg::OffsetWidth-dpsr_pkg::CapWidth){1'b0}}, cap_length_q}
                        + dpsr_pkg::CmdRingOffset;
  assign slot_base[1] = {{(dpsr_pkg::OffsetWidth-dpsr_pkg::CapWidth){1'b0}}, cap_length_q}
                        + dpsr_pkg::CtxArrayOffset;
  assign slot_base[2] = runtime_offset_q + dpsr_pkg::EvtTableOffset;
  assign slot_base[3] = runtime_offset_q + dpsr_pkg::DeqPtrOffset;

  for (genvar g = 0; g < dpsr_pkg::NumShadows; g++) begin : gen_match
    dpsr_slot_match u_match (
      .base_i          (slot_base[g]),
      .access_offset_i (s1_offset_q),
      .size_i          (s1_size_q[1:0]),
      .match_o         (slot_match[g])
    );
  end

  assign size_ok = (s1_size_q <= dpsr_pkg::SizeCodeMax);

  // First containing register wins; an illegal size code reports no hit.
  always_comb begin
    any_hit  = size_ok;
    sel_idx  = 2'd0;
    sel_lane = slot_match[0].lane;
    hit_d    = dpsr_pkg::HIT_CMD_RING;
    if (slot_match[0].hit) begin
      sel_idx  = 2'd0;
      sel_lane = slot_match[0].lane;
      hit_d    = dpsr_pkg::HIT_CMD_RING;
    end else if (slot_match[1].hit) begin
      sel_idx  = 2'd1;
      sel_lane = slot_match[1].lane;
      hit_d    = dpsr_pkg::HIT_CTX_ARRAY;
    end else if (slot_match[2].hit) begin
      sel_idx  = 2'd2;
      sel_lane = slot_match[2].lane;
      hit_d    = dpsr_pkg::HIT_EVT_TABLE;
    end else if (slot_match[3].hit) begin
      sel_idx  = 2'd3;
      sel_lane = slot_match[3].lane;
      hit_d    = dpsr_pkg::HIT_DEQ_PTR;
    end else begin
      any_hit = 1'b0;
    end
    if (!any_hit) begin
      hit_d = dpsr_pkg::HIT_NONE;
    end
  end

  always_comb begin
    case (s1_size_q[1:0])
      2'd0:    size_lanes = 8'h01;
      2'd1:    size_lanes = 8'h03;
      2'd2:    size_lanes = 8'h0F;
      default: size_lanes = 8'hFF;
    endcase
    lane_en      = size_lanes << sel_lane;
    data_shifted = s1_data_q << {sel_lane, 3'b000};
  end

  for (genvar b = 0; b < 8; b++) begin : gen_lane_mask
    assign lane_mask[b*8 +: 8] = {8{lane_en[b]}};
  end

  assign merged  = (shadow_q[sel_idx] & ~lane_mask) | (data_shifted & lane_mask);
  assign value_d = any_hit ? merged : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < dpsr_pkg::NumShadows; k++) begin
        shadow_q[k] <= '0;
      end
    end else if (advance && s1_valid_q && any_hit) begin
      shadow_q[sel_idx] <= merged;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      hit_q   <= hit_d;
      value_q <= value_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_register_o = hit_q;
  assign shadow_value_o = value_q;

  // A miss always reports a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (hit_register_o == dpsr_pkg::HIT_NONE) |-> shadow_value_o == '0)
    else $error("miss result carries a nonzero value");

  // The command ring shadow only changes together with a result that reports it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(shadow_q[0]) |-> out_valid_o && (hit_register_o == dpsr_pkg::HIT_CMD_RING)
                              && (shadow_value_o == shadow_q[0]))
    else $error("command ring shadow changed without a matching result");

  // An illegal size code never reports a hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_valid_q && !size_ok |=> hit_register_o == dpsr_pkg::HIT_NONE)
    else $error("illegal size code reported a hit");

  // Stall is raised only with an item held in the input stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with an empty pipeline");

endmodule

`default_nettype wire

// ===== tb/dpsr_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the DMA pointer shadow registers testbench: tracks the shadow
// registers and configuration, predicts each result and checks what the block returns.
// Depends on dpsr_pkg.

package dpsr_tb_pkg;

  import dpsr_pkg::*;

  typedef struct packed {
    hit_e                 hit;
    logic [DataWidth-1:0] value;
  } shadow_update_t;

  class pointer_shadow_scoreboard;

    logic [CapWidth-1:0]    cap_length;
    logic [OffsetWidth-1:0] runtime_offset;
    logic [DataWidth-1:0]   shadow[NumShadows];
    shadow_update_t         expected_q[$];
    int unsigned            mismatches;
    int unsigned            results_checked;
    int unsigned            hit_count[NumShadows + 1];

    function new();
      cap_length = '0;
      runtime_offset = '0;
      foreach (shadow[i]) shadow[i] = '0;
      foreach (hit_count[i]) hit_count[i] = 0;
      mismatches = 0;
      results_checked = 0;
    endfunction

    function void set_config(logic [CfgIndexWidth-1:0] index, logic [CfgDataWidth-1:0] data);
      case (index)
        CfgCapLength:     cap_length = data[CapWidth-1:0];
        CfgRuntimeOffset: runtime_offset = data;
        default: ;
      endcase
    endfunction

    // Register bases wrap at 32 bits; slots are listed in priority order.
    function void slot_info(int unsigned slot, output logic [OffsetWidth-1:0] base,
                            output hit_e code);
      case (slot)
        0: begin
          base = {24'd0, cap_length} + CmdRingOffset;
          code = HIT_CMD_RING;
        end
        1: begin
          base = {24'd0, cap_length} + CtxArrayOffset;
          code = HIT_CTX_ARRAY;
        end
        2: begin
          base = runtime_offset + EvtTableOffset;
          code = HIT_EVT_TABLE;
        end
        default: begin
          base = runtime_offset + DeqPtrOffset;
          code = HIT_DEQ_PTR;
        end
      endcase
    endfunction

    function void note_write(logic [OffsetWidth-1:0] offset, logic [DataWidth-1:0] data,
                             logic [2:0] size_code);
      shadow_update_t         upd;
      logic [OffsetWidth-1:0] base;
      hit_e                   code;
      longint unsigned        nbytes;
      logic [DataWidth-1:0]   lane_mask;
      int unsigned            shift;
      bit                     found;
      upd.hit = HIT_NONE;
      upd.value = '0;
      found = 1'b0;
      if (size_code <= SizeCodeMax) begin
        nbytes = 64'd1 << size_code;
        for (int unsigned i = 0; i < NumShadows && !found; i++) begin
          slot_info(i, base, code);
          // The containment test runs on unwrapped sums, so a register ending at
          // the top of the window still holds its last bytes.
          if (64'(offset) >= 64'(base) && 64'(offset) + nbytes <= 64'(base) + 64'd8) begin
            shift = (offset - base) * 8;
            lane_mask = (nbytes == 8) ? '1 : (((64'd1 << (nbytes * 8)) - 64'd1) << shift);
            shadow[i] = (shadow[i] & ~lane_mask) | ((data << shift) & lane_mask);
            upd.hit = code;
            upd.value = shadow[i];
            found = 1'b1;
          end
        end
      end
      expected_q.push_back(upd);
    endfunction

    function void check_result(logic [2:0] hit, logic [DataWidth-1:0] value);
      shadow_update_t exp_upd;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result hit=%0d value=%h", hit, value);
        return;
      end
      exp_upd = expected_q.pop_front();
      results_checked++;
      hit_count[exp_upd.hit]++;
      if (hit !== exp_upd.hit || value !== exp_upd.value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d: expected hit=%0d value=%h, got hit=%0d value=%h",
                   results_checked, exp_upd.hit, exp_upd.value, hit, value);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

  endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the testbench for dma_pointer_shadow_registers_core: clock, reset,
// write and configuration drivers, result sink and end-of-run report.
// Depends on dpsr_pkg, dpsr_tb_pkg and the core RTL.

module tb_top;

  import dpsr_pkg::*;
  import dpsr_tb_pkg::*;

  localparam int unsigned IdleLimit     = 1000;
  localparam int unsigned ItemsPerPhase = 113;
  localparam int unsigned RandomPhases  = 10;
  localparam int unsigned HoldCycles    = 60;

  localparam logic [2:0] Size1 = 3'd0;
  localparam logic [2:0] Size2 = 3'd1;
  localparam logic [2:0] Size4 = 3'd2;
  localparam logic [2:0] Size8 = 3'd3;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic [OffsetWidth-1:0]   access_offset = '0;
  logic [DataWidth-1:0]     write_data = '0;
  logic [2:0]               size_code = '0;
  logic                     out_stall = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data = '0;

  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [2:0]           hit_register_o;
  logic [DataWidth-1:0] shadow_value_o;
  logic                 cfg_ready_o;

  pointer_shadow_scoreboard shadow_tracker = new();

  bit          steady = 1'b0;
  int unsigned hold_request = 0;
  int unsigned idle_cycles = 0;
  int unsigned writes_sent = 0;
  int unsigned settings_used = 1;

  dma_pointer_shadow_registers_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .access_offset_i(access_offset),
    .write_data_i   (write_data),
    .size_code_i    (size_code),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .hit_register_o (hit_register_o),
    .shadow_value_o (shadow_value_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #6 clk_i = ~clk_i;

  // Inputs are noted before results are checked so a same-edge pair stays ordered.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o)
        shadow_tracker.note_write(access_offset, write_data, size_code);
      if (out_valid_o && !out_stall)
        shadow_tracker.check_result(hit_register_o, shadow_value_o);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
          (cfg_valid && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no transaction for %0d cycles", IdleLimit);
        $display("FAIL dma_pointer_shadow_registers_core");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_request != 0) begin
        gap = hold_request;
        hold_request = 0;
      end else begin
        gap = steady ? 0 : $urandom_range(0, 3);
      end
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  task automatic send_write(input logic [OffsetWidth-1:0] offset,
                            input logic [DataWidth-1:0] data, input logic [2:0] code);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    access_offset <= offset;
    write_data <= data;
    size_code <= code;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    writes_sent++;
  endtask

  // Most writes land near a register base so that hits, partial overlaps and
  // lane merges dominate; the rest are spread over the whole window.
  task automatic random_write();
    logic [OffsetWidth-1:0] base;
    logic [OffsetWidth-1:0] offset;
    logic [DataWidth-1:0]   data;
    logic [2:0]             size;
    hit_e                   slot_code;
    case ($urandom_range(0, 7))
      0:       data = '0;
      1:       data = '1;
      default: data = {$urandom, $urandom};
    endcase
    if ($urandom_range(0, 99) < 80) begin
      shadow_tracker.slot_info($urandom_range(0, 3), base, slot_code);
      offset = base + $urandom_range(0, 15) - 32'd4;
      size = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
    end else begin
      offset = $urandom;
      size = 3'($urandom_range(0, 7));
    end
    send_write(offset, data, size);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (shadow_tracker.pending() != 0);
  endtask

  // Both registers are written back to back; valid stays high between them.
  task automatic write_config(input logic [CfgDataWidth-1:0] cap_data,
                              input logic [CfgDataWidth-1:0] rt_data);
    cfg_valid <= 1'b1;
    cfg_index <= CfgCapLength;
    cfg_data <= cap_data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    shadow_tracker.set_config(CfgCapLength, cap_data);
    cfg_index <= CfgRuntimeOffset;
    cfg_data <= rt_data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    shadow_tracker.set_config(CfgRuntimeOffset, rt_data);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    logic [CfgDataWidth-1:0] cap_data;
    logic [CfgDataWidth-1:0] rt_data;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: command ring at 0x18, context array and event table both
    // at 0x30 (context array wins), dequeue pointer at 0x38.
    send_write(32'h18, '1, Size8);
    send_write(32'h1F, 64'hFFFF_FFFF_FFFF_FF5A, Size1);
    send_write(32'h1A, 64'hABCD_0000_FFFF_1234, Size2);
    send_write(32'h1C, 64'h0, Size4);
    send_write(32'h1E, 64'h1111_2222, Size4);
    for (int unsigned c = 4; c < 8; c++)
      send_write(32'h18, '1, 3'(c));
    send_write(32'h30, 64'h0123_4567_89AB_CDEF, Size8);
    send_write(32'h3C, 64'h55AA_55AA, Size4);
    send_write(32'h38, '1, Size8);
    send_write(32'h17, '1, Size1);
    send_write(32'hFFFF_FFFF, '1, Size1);
    send_write(32'h0, '0, Size8);
    drain();

    // Largest cap length; the event table ends exactly at the top of the window
    // and the dequeue pointer base wraps around to zero.
    write_config(32'hFFFF_FFFF, 32'hFFFF_FFC8);
    send_write(32'hFFFF_FFFC, 64'hDEAD_BEEF, Size4);
    send_write(32'hFFFF_FFF8, '1, Size8);
    send_write(32'hFFFF_FFFF, 64'h0, Size1);
    send_write(32'h0, 64'h77, Size1);
    send_write(32'h117, 64'hFEDC_BA98_7654_3210, Size8);
    send_write(32'h135, 64'hBEEF, Size2);
    send_write(32'h136, 64'hC3, Size1);
    send_write(32'h11B, 64'h1234_5678_9ABC_DEF0, Size8);
    drain();

    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      case (phase % 5)
        0: begin
          cap_data = $urandom;
          rt_data = $urandom;
        end
        1: begin
          cap_data = 32'h0000_00FF;
          rt_data = 32'hFFFF_FFFF;
        end
        2: begin
          // Event table placed on top of the command ring to test priority.
          cap_data = $urandom_range(0, 255);
          rt_data = cap_data - 32'h18;
        end
        3: begin
          cap_data = 32'h0;
          rt_data = 32'hFFFF_FFC8 + $urandom_range(0, 8);
        end
        default: begin
          cap_data = $urandom_range(0, 255);
          rt_data = $urandom_range(0, 511);
        end
      endcase
      write_config(cap_data, rt_data);
      steady = (phase % 3 == 1) || (phase == 4);
      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        // The sink holds off while writes keep coming, so the pipeline backs up.
        if (phase == 4 && n == 30)
          hold_request = HoldCycles;
        random_write();
      end
      drain();
    end

    repeat (4) @(posedge clk_i);
    $display("Summary: %0d writes, %0d results checked over %0d register settings.",
             writes_sent, shadow_tracker.results_checked, settings_used);
    $display("Hits: command ring %0d, context array %0d, event table %0d, dequeue %0d, none %0d.",
             shadow_tracker.hit_count[HIT_CMD_RING], shadow_tracker.hit_count[HIT_CTX_ARRAY],
             shadow_tracker.hit_count[HIT_EVT_TABLE], shadow_tracker.hit_count[HIT_DEQ_PTR],
             shadow_tracker.hit_count[HIT_NONE]);
    if (shadow_tracker.mismatches == 0 && shadow_tracker.pending() == 0) begin
      $display("PASS dma_pointer_shadow_registers_core");
    end else begin
      $display("Mismatches: %0d, results still outstanding: %0d",
               shadow_tracker.mismatches, shadow_tracker.pending());
      $display("FAIL dma_pointer_shadow_registers_core");
    end
    $finish;
  end

endmodule
